>>> hw/rtl/selective_ack_window_tracker_defines.svh
// Assertion macros used by the checker file of the ack window tracker
`ifndef SELECTIVE_ACK_WINDOW_TRACKER_DEFINES_SVH
`define SELECTIVE_ACK_WINDOW_TRACKER_DEFINES_SVH

// Clocked assertion, masked while reset is held low
`define SAWT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also runs through reset
`define SAWT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/sawt_pkg.sv
// Shared constants, status codes and control structs of the ack window tracker
package sawt_pkg;

    localparam int WINDOW   = 5;
    localparam int DEPTH    = 5;
    localparam int SLOT_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TYPE_W   = 8;
    localparam int IDX_W    = 31;
    localparam int CUM_W    = 32;
    localparam int STATUS_W = 3;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 64;

    localparam logic [TYPE_W-1:0] ACK_CODE  = 8'd2;
    localparam logic [IDX_W-1:0]  IDX_MAX   = {IDX_W{1'b1}};
    localparam logic [IDX_W-1:0]  TOTAL_RST = 31'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADVANCED = 3'd0,
        ST_BUFFERED = 3'd1,
        ST_IGNORED  = 3'd2,
        ST_INVALID  = 3'd3,
        ST_DROPPED  = 3'd4
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic capture;  // latch the incoming transaction
        logic eval;     // classify the latched ack and apply it
        logic drain;    // one drain step over the pending slots
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic advance;  // latched ack is the next expected index
        logic hit;      // a pending slot holds the next expected index
    } t_stat;

endpackage

>>> hw/rtl/sawt_ctrl.sv
// Controller state machine: input capture, evaluation, drain loop, result handoff
module sawt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  sawt_pkg::t_stat i_stat,
    output sawt_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DRAIN
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;
    logic   w_load;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && r_in_ready && i_in_valid;
        o_cmd.eval    = (r_state == S_EVAL) && w_out_free;
        o_cmd.drain   = (r_state == S_DRAIN);
    end

    always_comb begin
        n_state    = r_state;
        n_in_ready = r_in_ready;
        w_load     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (r_in_ready && i_in_valid) begin
                    n_state    = S_EVAL;
                    n_in_ready = 1'b0;
                end
            end
            S_EVAL: begin
                // hold until the result register can take a new value
                if (w_out_free) begin
                    if (i_stat.advance) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_state    = S_IDLE;
                        n_in_ready = 1'b1;
                        w_load     = 1'b1;
                    end
                end
            end
            S_DRAIN: begin
                if (!i_stat.hit) begin
                    n_state    = S_IDLE;
                    n_in_ready = 1'b1;
                    w_load     = 1'b1;
                end
            end
            default: begin
                n_state    = S_IDLE;
                n_in_ready = 1'b1;
            end
        endcase
        n_out_valid = w_load ? 1'b1 : (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= n_in_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

>>> hw/rtl/sawt_dp.sv
// Datapath: cumulative ack, pending slots, transfer length and result register
module sawt_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sawt_pkg::t_cmd                     i_cmd,
    output sawt_pkg::t_stat                    o_stat,
    input  logic [sawt_pkg::TYPE_W-1:0]        i_in_type,
    input  logic [sawt_pkg::IDX_W-1:0]         i_in_idx,
    input  logic                               i_cfg_we,
    input  logic [sawt_pkg::IDX_W-1:0]         i_cfg_data,
    output logic [sawt_pkg::STATUS_W-1:0]      o_status,
    output logic [sawt_pkg::CUM_W-1:0]         o_last_acked,
    output logic [sawt_pkg::IDX_W-1:0]         o_send_limit,
    output logic                               o_done
);

    localparam int D = sawt_pkg::DEPTH;

    logic signed [sawt_pkg::CUM_W-1:0] r_cum, n_cum;
    logic [sawt_pkg::IDX_W-1:0]        r_total;
    logic [sawt_pkg::IDX_W-1:0]        r_slot [D];
    logic [D-1:0]                      r_vld, n_vld;
    logic [sawt_pkg::TYPE_W-1:0]       r_type;
    logic [sawt_pkg::IDX_W-1:0]        r_idx;

    logic [sawt_pkg::STATUS_W-1:0]     r_out_status;
    logic [sawt_pkg::CUM_W-1:0]        r_out_last;
    logic [sawt_pkg::IDX_W-1:0]        r_out_limit;
    logic                              r_out_done;

    logic [sawt_pkg::CUM_W-1:0]        w_cum_inc;
    logic signed [sawt_pkg::CUM_W:0]   w_cum33;
    logic signed [sawt_pkg::CUM_W:0]   w_cum_win;
    logic signed [sawt_pkg::CUM_W:0]   w_idx33;
    logic signed [sawt_pkg::CUM_W:0]   w_total_m1;
    logic                              w_done;
    logic                              w_is_ack;
    logic                              w_advance;
    logic                              w_in_win;
    logic [D-1:0]                      w_match;
    logic [D-1:0]                      w_stale;
    logic                              w_free_any;
    logic [sawt_pkg::SLOT_W-1:0]       w_free_sel;
    sawt_pkg::t_status                 w_status;
    logic [sawt_pkg::IDX_W-1:0]        w_limit;
    logic                              w_load;

    assign w_cum_inc  = r_cum + 32'd1;
    assign w_cum33    = {r_cum[sawt_pkg::CUM_W-1], r_cum};
    assign w_cum_win  = w_cum33 + 33'(sawt_pkg::WINDOW);
    assign w_idx33    = {2'b00, r_idx};
    assign w_total_m1 = $signed({2'b00, r_total}) - 33'sd1;
    assign w_done     = w_cum33 >= w_total_m1;
    assign w_is_ack   = (r_type == sawt_pkg::ACK_CODE);
    assign w_advance  = w_is_ack && !w_done && ({1'b0, r_idx} == w_cum_inc);
    assign w_in_win   = (w_idx33 > w_cum33) && (w_idx33 <= w_cum_win);

    // per-slot compares against the next expected index and the acked range
    always_comb begin
        for (int k = 0; k < D; k++) begin
            w_match[k] = r_vld[k] && ({1'b0, r_slot[k]} == w_cum_inc);
            w_stale[k] = r_vld[k] && ($signed({1'b0, r_slot[k]}) <= r_cum);
        end
    end

    // lowest free slot
    always_comb begin
        w_free_any = 1'b0;
        w_free_sel = '0;
        for (int k = D - 1; k >= 0; k--) begin
            if (!r_vld[k]) begin
                w_free_any = 1'b1;
                w_free_sel = sawt_pkg::SLOT_W'(k);
            end
        end
    end

    always_comb begin
        if (!w_is_ack) begin
            w_status = sawt_pkg::ST_INVALID;
        end else if (w_done) begin
            w_status = sawt_pkg::ST_IGNORED;
        end else if (w_advance) begin
            w_status = sawt_pkg::ST_ADVANCED;
        end else if (w_in_win) begin
            w_status = w_free_any ? sawt_pkg::ST_BUFFERED : sawt_pkg::ST_DROPPED;
        end else begin
            w_status = sawt_pkg::ST_IGNORED;
        end
    end

    // saturate the send limit at the top of the index range
    always_comb begin
        if (w_cum_win > $signed({2'b00, sawt_pkg::IDX_MAX})) begin
            w_limit = sawt_pkg::IDX_MAX;
        end else begin
            w_limit = w_cum_win[sawt_pkg::IDX_W-1:0];
        end
    end

    always_comb begin
        n_cum  = r_cum;
        n_vld  = r_vld;
        w_load = 1'b0;
        if (i_cmd.eval) begin
            if (w_advance) begin
                n_cum = w_cum_inc;
            end else begin
                w_load = 1'b1;
                if (w_status == sawt_pkg::ST_BUFFERED) begin
                    n_vld[w_free_sel] = 1'b1;
                end
            end
        end else if (i_cmd.drain) begin
            if (|w_match) begin
                n_cum = w_cum_inc;
                n_vld = r_vld & ~w_match;
            end else begin
                // drop every slot now covered by the cumulative ack
                n_vld  = r_vld & ~w_stale;
                w_load = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cum   <= '1;
            r_vld   <= '0;
            r_total <= sawt_pkg::TOTAL_RST;
        end else begin
            r_cum <= n_cum;
            r_vld <= n_vld;
            if (i_cfg_we) begin
                r_total <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_type <= i_in_type;
            r_idx  <= i_in_idx;
        end
        if (i_cmd.eval && !w_advance && (w_status == sawt_pkg::ST_BUFFERED)) begin
            r_slot[w_free_sel] <= r_idx;
        end
        if (w_load) begin
            r_out_status <= i_cmd.drain ? sawt_pkg::ST_ADVANCED : w_status;
            r_out_last   <= r_cum;
            r_out_limit  <= w_limit;
            r_out_done   <= w_done;
        end
    end

    assign o_stat.advance = w_advance;
    assign o_stat.hit     = |w_match;
    assign o_status       = r_out_status;
    assign o_last_acked   = r_out_last;
    assign o_send_limit   = r_out_limit;
    assign o_done         = r_out_done;

endmodule

>>> hw/rtl/selective_ack_window_tracker.sv
// Top level of the selective-repeat sender ack window tracker
//
//  channel   dir  handshake                          payload
//  s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tuser msg_type, tdata ack_index
//  m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tuser status, tdata results
//  cfg       in   i_cfg_valid / o_cfg_ready          total_packets
//
// An ack that does not advance is captured, then evaluated; an advancing ack is
// captured, evaluated, then drains the n distinct buffered indices (0..4, a parked
// ack always sits at least two past the cumulative index) and loads the result on
// a drain step without a match; the drain loop retires one index per cycle
// against a single compare bank. Reset is synchronous and active low; no clearing
// pass follows it. A new transaction is taken while the previous result waits in
// the output register; evaluation stalls until that register is free.
module selective_ack_window_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [30:0] ack_index, [31] zero pad
    input  logic [7:0]  i_s_axis_tuser,   // [7:0] msg_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [31:0] last_acked, [62:32] send_limit,
                                          // [63] done_res
    output logic [2:0]  o_m_axis_tuser,   // [2:0] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [30:0] i_cfg_data        // [30:0] total_packets
);

    sawt_pkg::t_cmd  w_cmd;
    sawt_pkg::t_stat w_stat;
    logic [sawt_pkg::CUM_W-1:0] w_last;
    logic [sawt_pkg::IDX_W-1:0] w_limit;
    logic                       w_done;

    assign o_cfg_ready = 1'b1;

    sawt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    sawt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_in_type    (i_s_axis_tuser),
        .i_in_idx     (i_s_axis_tdata[sawt_pkg::IDX_W-1:0]),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_status     (o_m_axis_tuser),
        .o_last_acked (w_last),
        .o_send_limit (w_limit),
        .o_done       (w_done)
    );

    assign o_m_axis_tdata = {w_done, w_limit, w_last};

endmodule

>>> hw/rtl/sawt_checker.sv
// Port-level checker for the ack window tracker, bound to the top level
`include "selective_ack_window_tracker_defines.svh"

module sawt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser
);

    `SAWT_ASSERT_ALWAYS(a_rst_no_result, i_clk, !i_rst_n |=> !o_m_axis_tvalid,
        "result valid right after reset")

    `SAWT_ASSERT(a_status_code, i_clk, i_rst_n,
        o_m_axis_tvalid |-> (o_m_axis_tuser <= sawt_pkg::ST_DROPPED),
        "undefined status code")

    `SAWT_ASSERT(a_limit_sum, i_clk, i_rst_n,
        (o_m_axis_tvalid && !o_m_axis_tdata[31] && o_m_axis_tdata[30:0] <= 31'h7FFF_FFFA)
            |-> (o_m_axis_tdata[62:32] == o_m_axis_tdata[30:0] + 31'd5),
        "send limit is not last acked plus window")

    `SAWT_ASSERT(a_limit_none, i_clk, i_rst_n,
        (o_m_axis_tvalid && o_m_axis_tdata[31:0] == 32'hFFFF_FFFF)
            |-> (o_m_axis_tdata[62:32] == 31'd4),
        "send limit wrong with nothing acked")

    `SAWT_ASSERT(a_out_hold, i_clk, i_rst_n,
        (o_m_axis_tvalid && !i_m_axis_tready)
            |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)),
        "stalled result changed")

endmodule

bind selective_ack_window_tracker sawt_checker u_sawt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

>>> verif/tb.sv
// Self-checking testbench for the selective-repeat ack window tracker
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int ITEMS_PER_RUN = 380;

    typedef struct packed {
        sawt_pkg::t_status                status;
        logic signed [31:0]               last_acked;
        logic [sawt_pkg::IDX_W-1:0]       send_limit;
        logic                             done;
    } t_ack_result;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_valid = 1'b0;
    logic [31:0]                 s_data = '0;
    logic [7:0]                  s_user = '0;
    logic                        m_ready = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic [sawt_pkg::IDX_W-1:0]  cfg_data = '0;
    logic                        o_s_axis_tready;
    logic                        o_m_axis_tvalid;
    logic [63:0]                 o_m_axis_tdata;
    logic [2:0]                  o_m_axis_tuser;
    logic                        o_cfg_ready;

    // Tracker state as predicted by the testbench
    longint                      cum_ack;
    logic [sawt_pkg::IDX_W-1:0]  slot_idx [sawt_pkg::DEPTH];
    bit                          slot_vld [sawt_pkg::DEPTH];
    logic [sawt_pkg::IDX_W-1:0]  total_cfg;

    t_ack_result       ack_result_q [$];
    int                src_idle_pct = 0;
    int                sink_stall_pct = 0;
    int                err_count = 0;
    int                n_sent = 0;
    int                n_checked = 0;
    int                status_seen [5] = '{default: 0};
    int                cycle_count = 0;

    selective_ack_window_tracker uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic bit xfer_done();
        return cum_ack >= longint'(total_cfg) - 1;
    endfunction

    // Apply one message to the predicted state and return the result it yields
    function automatic t_ack_result track_ack(input logic [7:0] mtype,
                                              input logic [sawt_pkg::IDX_W-1:0] idx);
        t_ack_result r;
        longint      ix;
        longint      lim;
        bit          hit;
        bit          placed;
        ix = longint'(idx);
        if (mtype != sawt_pkg::ACK_CODE) begin
            r.status = sawt_pkg::ST_INVALID;
        end else if (xfer_done()) begin
            r.status = sawt_pkg::ST_IGNORED;
        end else if (ix == cum_ack + 1) begin
            cum_ack++;
            hit = 1'b1;
            for (int p = 0; p < sawt_pkg::DEPTH && hit; p++) begin
                hit = 1'b0;
                for (int k = 0; k < sawt_pkg::DEPTH; k++) begin
                    if (!hit && slot_vld[k] && longint'(slot_idx[k]) == cum_ack + 1) begin
                        cum_ack++;
                        slot_vld[k] = 1'b0;
                        hit = 1'b1;
                    end
                end
            end
            // free slots that the advance left behind
            for (int k = 0; k < sawt_pkg::DEPTH; k++)
                if (slot_vld[k] && longint'(slot_idx[k]) <= cum_ack)
                    slot_vld[k] = 1'b0;
            r.status = sawt_pkg::ST_ADVANCED;
        end else if (ix > cum_ack && ix <= cum_ack + sawt_pkg::WINDOW) begin
            placed = 1'b0;
            for (int k = 0; k < sawt_pkg::DEPTH; k++) begin
                if (!placed && !slot_vld[k]) begin
                    slot_vld[k] = 1'b1;
                    slot_idx[k] = idx;
                    placed = 1'b1;
                end
            end
            r.status = placed ? sawt_pkg::ST_BUFFERED : sawt_pkg::ST_DROPPED;
        end else begin
            r.status = sawt_pkg::ST_IGNORED;
        end
        lim = cum_ack + sawt_pkg::WINDOW;
        if (lim > longint'(sawt_pkg::IDX_MAX))
            lim = longint'(sawt_pkg::IDX_MAX);
        if (lim < 0)
            lim = 0;
        r.last_acked = cum_ack[31:0];
        r.send_limit = lim[sawt_pkg::IDX_W-1:0];
        r.done = xfer_done();
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_ack_result want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (ack_result_q.size() == 0) begin
                $error("result transaction with no prediction pending");
                err_count++;
            end else begin
                want = ack_result_q.pop_front();
                n_checked++;
                if (o_m_axis_tuser < 5)
                    status_seen[o_m_axis_tuser]++;
                if (o_m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_m_axis_tuser);
                    err_count++;
                end
                if (o_m_axis_tdata[31:0] !== want.last_acked) begin
                    $error("last_acked: expected %0d, got %0d", want.last_acked,
                           $signed(o_m_axis_tdata[31:0]));
                    err_count++;
                end
                if (o_m_axis_tdata[62:32] !== want.send_limit) begin
                    $error("send_limit: expected %0d, got %0d", want.send_limit,
                           o_m_axis_tdata[62:32]);
                    err_count++;
                end
                if (o_m_axis_tdata[63] !== want.done) begin
                    $error("done_res: expected %0d, got %0d", want.done, o_m_axis_tdata[63]);
                    err_count++;
                end
            end
        end
    end

    // Hold valid across back-to-back transactions; drop it only when idling
    task automatic send_msg(input logic [7:0] mtype, input logic [sawt_pkg::IDX_W-1:0] idx);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        ack_result_q.push_back(track_ack(mtype, idx));
        s_valid <= 1'b1;
        s_user  <= mtype;
        s_data  <= {1'b0, idx};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        n_sent++;
    endtask

    // Ack at an offset from the current cumulative index, clipped to the field
    task automatic send_ack_rel(input longint off);
        longint ix;
        ix = cum_ack + off;
        if (ix < 0)
            ix = 0;
        if (ix > longint'(sawt_pkg::IDX_MAX))
            ix = longint'(sawt_pkg::IDX_MAX);
        send_msg(sawt_pkg::ACK_CODE, ix[sawt_pkg::IDX_W-1:0]);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (ack_result_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_total(input logic [sawt_pkg::IDX_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        total_cfg = value;
    endtask

    task automatic test_reset_state();
        send_msg(8'd0, '0);
        send_msg(sawt_pkg::ACK_CODE, '0);
        send_msg(sawt_pkg::ACK_CODE, 31'd1);
        send_msg(8'hFF, sawt_pkg::IDX_MAX);
    endtask

    task automatic test_zero_total();
        write_total('0);
        send_ack_rel(1);
        send_msg(8'd1, 31'd1);
    endtask

    task automatic test_window_cases();
        write_total(sawt_pkg::IDX_MAX);
        send_ack_rel(1);
        send_ack_rel(3);
        send_ack_rel(3);
        send_ack_rel(sawt_pkg::WINDOW);
        send_ack_rel(sawt_pkg::WINDOW + 1);
        send_ack_rel(0);
        send_msg(sawt_pkg::ACK_CODE, sawt_pkg::IDX_MAX);
        send_ack_rel(4);
        send_ack_rel(2);
        // all slots taken: next in-window ack is dropped
        send_ack_rel(3);
        // advance drains the run and frees the duplicate
        send_ack_rel(1);
        send_ack_rel(2);
        send_ack_rel(1);
        send_msg(8'd3, 31'h5555_5555);
        send_msg(8'h80, 31'h2AAA_AAAA);
        send_msg(8'h7F, '0);
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct);
        int          r;
        int          pick;
        logic [7:0]  mtype;
        logic [31:0] raw;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int n = 0; n < ITEMS_PER_RUN; n++) begin
            // new transfer length every few dozen messages, sometimes open-ended
            if (n % 60 == 0) begin
                r = $urandom_range(9);
                if (r == 0)
                    write_total(sawt_pkg::IDX_MAX);
                else if (r == 1)
                    write_total(31'd1);
                else
                    write_total(31'(cum_ack + 1 + $urandom_range(12, 50)));
            end
            r = $urandom_range(99);
            if (r < 8) begin
                mtype = 8'($urandom_range(255));
                raw = $urandom;
                send_msg(mtype, raw[sawt_pkg::IDX_W-1:0]);
            end else if (r < 16) begin
                raw = $urandom;
                send_msg(sawt_pkg::ACK_CODE, raw[sawt_pkg::IDX_W-1:0]);
            end else begin
                pick = $urandom_range(99);
                if (pick < 30)
                    send_ack_rel(1);
                else if (pick < 80)
                    send_ack_rel($urandom_range(2, sawt_pkg::WINDOW));
                else if (pick < 90)
                    send_ack_rel($urandom_range(sawt_pkg::WINDOW + 1, sawt_pkg::WINDOW + 3));
                else
                    send_ack_rel(-longint'($urandom_range(0, 3)));
            end
        end
        settle();
    endtask

    initial begin
        cum_ack   = -1;
        total_cfg = sawt_pkg::TOTAL_RST;
        for (int k = 0; k < sawt_pkg::DEPTH; k++) begin
            slot_vld[k] = 1'b0;
            slot_idx[k] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_zero_total();
        test_window_cases();
        test_random_traffic(20, 56);
        test_random_traffic(56, 20);
        test_random_traffic(0, 0);

        settle();
        $display("Run covered %0d messages and %0d checked results across three idle mixes",
                 n_sent, n_checked);
        $display("Statuses: advanced %0d, buffered %0d, ignored %0d, invalid %0d, dropped %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (err_count == 0 && ack_result_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
